>>> rtl/core/antialias_row_resampler_unit_macros.svh
// Assertion macros shared by the resampler checker.
// Used through `include by the assertion files; no other dependency.
`ifndef ANTIALIAS_ROW_RESAMPLER_UNIT_MACROS_SVH
`define ANTIALIAS_ROW_RESAMPLER_UNIT_MACROS_SVH

// Overlapping implication, checked on every rising edge outside reset.
`define ARR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("resampler check failed");

// Non-overlapping implication, consequent checked in the next cycle.
`define ARR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("resampler check failed");

`endif

>>> rtl/core/arr_pkg.sv
// Shared constants, codes and types of the row resampler.
// No dependencies; used by arr_lane, the top level and the checker.
package arr_pkg;

    localparam int LINE_AW      = 11;
    localparam int OUT_AW       = 10;
    localparam int TAP_AW       = 5;
    localparam int TAPS_MAX     = 32;
    localparam int PRECISION    = 22;
    localparam int WEIGHT_W     = 23;
    localparam int ACC_W        = 36;
    localparam int LANES        = 4;
    localparam int WIN_W        = 17;
    localparam int RESULT_LIMIT = 64;
    localparam logic [11:0] LINE_MAX = 12'd2048;
    localparam logic [10:0] OUT_MAX  = 11'd1024;

    localparam logic [1:0] REQ_WEIGHT = 2'd0;
    localparam logic [1:0] REQ_WINDOW = 2'd1;
    localparam logic [1:0] REQ_PIXEL  = 2'd2;
    localparam logic [1:0] REQ_RSVD   = 2'd3;

    localparam logic [3:0] ADDR_SRC_WIDTH     = 4'h0;
    localparam logic [3:0] ADDR_DST_WIDTH     = 4'h4;
    localparam logic [3:0] ADDR_CHANNEL_COUNT = 4'h8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WIN,
        ST_CHECK,
        ST_TAP,
        ST_STORE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic clear;
        logic acc;
    } lane_ctl_t;

endpackage

>>> rtl/core/arr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; holds the line store and the weight and window tables.
module arr_ram #(
    parameter int ADDR_W = 10,
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem_reg [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Read data holds while re is low.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

>>> rtl/core/arr_lane.sv
// One channel lane: multiply-accumulate over the taps, then round and clamp.
// Depends on arr_pkg.
module arr_lane (
    input  logic                         clk,
    input  arr_pkg::lane_ctl_t           ctl,
    input  logic [7:0]                   pix,
    input  logic [arr_pkg::WEIGHT_W-1:0] weight,
    output logic [7:0]                   res
);

    logic [arr_pkg::ACC_W-1:0] acc_reg;
    logic [arr_pkg::ACC_W-1:0] acc_next;
    logic [30:0]               prod;
    logic [arr_pkg::ACC_W-arr_pkg::PRECISION-1:0] shifted;

    assign prod = 31'(pix) * 31'(weight);

    always_comb
    begin
        acc_next = acc_reg;
        if (ctl.clear)
        begin
            // Start from one half so the final shift rounds to nearest.
            acc_next = arr_pkg::ACC_W'(1) << (arr_pkg::PRECISION - 1);
        end
        else if (ctl.acc)
        begin
            acc_next = acc_reg + arr_pkg::ACC_W'(prod);
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign shifted = acc_reg[arr_pkg::ACC_W-1:arr_pkg::PRECISION];
    assign res = (shifted > 14'd255) ? 8'd255 : shifted[7:0];

endmodule

>>> rtl/core/antialias_row_resampler_unit.sv
// Top level of the row resampler: handshakes, sequencer, tables and lanes.
// Depends on arr_pkg, arr_ram and arr_lane.
//
//  Channel  Dir  Beat fields
//  s_*      in   tuser req_type; tdata entry, tap, weight, first, count, chan0..3
//  m_*      out  tdata position, res0..res3; tlast run_last; tuser row_finished
//  apb      in   src_width @0x0, dst_width @0x4, channel_count @0x8
//
// A table write is taken in the idle state. A pixel is stored, then for each output
// the sequencer reads and checks the window, runs the tap loop and stores the result,
// stopping at an incomplete window; the tap loop reads one weight and one stored pixel
// per cycle and all four channel lanes accumulate in parallel.
// Reset clears counters and handshake state; the memories are not cleared.
// A stalled output beat holds the sequencer only when a second result is due.
module antialias_row_resampler_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,   // entry[9:0] tap[14:10] weight[37:15] first[48:38]
                                   // count[54:49] chan0[62:55] chan1[70:63]
                                   // chan2[78:71] chan3[86:79]
    input  logic [1:0]  s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // position[9:0] res0[17:10] res1[25:18]
                                   // res2[33:26] res3[41:34]
    output logic        m_tlast,   // run_last
    output logic        m_tuser,   // row_finished
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [11:0] in_width_reg;
    logic [10:0] out_width_reg;
    logic [2:0]  chan_cnt_reg;
    logic [11:0] in_w;
    logic [10:0] out_w;
    logic [2:0]  chans;

    arr_pkg::state_t state_reg, state_next;
    logic [11:0] pr_reg, pr_next;
    logic [10:0] nout_reg, nout_next;
    logic [6:0]  n_reg, n_next;
    logic        row_end_reg, row_end_next;
    logic [5:0]  k_reg, k_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [10:0] first_reg, first_next;
    logic        dvld_reg, dvld_next;
    logic        din_reg, din_next;
    logic        held_vld_reg, held_vld_next;
    logic [9:0]  held_pos_reg, held_pos_next;
    logic [31:0] held_res_reg, held_res_next;
    logic        held_fin_reg, held_fin_next;
    logic        out_vld_reg, out_vld_next;
    logic [47:0] out_data_reg, out_data_next;
    logic        out_last_reg, out_last_next;
    logic        out_user_reg, out_user_next;

    logic        w_we, win_we, line_we;
    logic        w_re, win_re, line_re;
    logic [22:0] w_rdata;
    logic [16:0] win_rdata;
    logic [31:0] line_rdata;
    logic [11:0] src;
    logic [5:0]  win_cnt;
    logic        out_free;
    logic        push;
    logic        push_last;
    arr_pkg::lane_ctl_t lane_ctl;
    logic [7:0]  lane_res [arr_pkg::LANES];

    // Configuration port.
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_width_reg  <= 12'd1;
            out_width_reg <= 11'd1;
            chan_cnt_reg  <= 3'd3;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr)
                arr_pkg::ADDR_SRC_WIDTH:     in_width_reg  <= pwdata[11:0];
                arr_pkg::ADDR_DST_WIDTH:     out_width_reg <= pwdata[10:0];
                arr_pkg::ADDR_CHANNEL_COUNT: chan_cnt_reg  <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr)
            arr_pkg::ADDR_SRC_WIDTH:     prdata = {20'd0, in_width_reg};
            arr_pkg::ADDR_DST_WIDTH:     prdata = {21'd0, out_width_reg};
            arr_pkg::ADDR_CHANNEL_COUNT: prdata = {29'd0, chan_cnt_reg};
            default:                     prdata = 32'd0;
        endcase
    end

    assign in_w  = (in_width_reg == 12'd0) ? 12'd1 :
                   (in_width_reg > arr_pkg::LINE_MAX) ? arr_pkg::LINE_MAX : in_width_reg;
    assign out_w = (out_width_reg == 11'd0) ? 11'd1 :
                   (out_width_reg > arr_pkg::OUT_MAX) ? arr_pkg::OUT_MAX : out_width_reg;
    assign chans = (chan_cnt_reg == 3'd0) ? 3'd1 :
                   (chan_cnt_reg > 3'd4) ? 3'd4 : chan_cnt_reg;

    // Storage.
    arr_ram #(.ADDR_W(arr_pkg::OUT_AW + arr_pkg::TAP_AW), .DATA_W(arr_pkg::WEIGHT_W)) u_weight (
        .clk   (clk),
        .we    (w_we),
        .waddr ({s_tdata[9:0], s_tdata[14:10]}),
        .wdata (s_tdata[37:15]),
        .re    (w_re),
        .raddr ({nout_reg[9:0], k_reg[4:0]}),
        .rdata (w_rdata)
    );

    arr_ram #(.ADDR_W(arr_pkg::OUT_AW), .DATA_W(arr_pkg::WIN_W)) u_window (
        .clk   (clk),
        .we    (win_we),
        .waddr (s_tdata[9:0]),
        .wdata ({s_tdata[54:49], s_tdata[48:38]}),
        .re    (win_re),
        .raddr (nout_reg[9:0]),
        .rdata (win_rdata)
    );

    arr_ram #(.ADDR_W(arr_pkg::LINE_AW), .DATA_W(32)) u_line (
        .clk   (clk),
        .we    (line_we),
        .waddr (pr_reg[10:0]),
        .wdata (s_tdata[86:55]),
        .re    (line_re),
        .raddr (src[10:0]),
        .rdata (line_rdata)
    );

    // Channel lanes.
    for (genvar c = 0; c < arr_pkg::LANES; c++)
    begin : g_lane
        arr_lane u_lane (
            .clk    (clk),
            .ctl    (lane_ctl),
            .pix    (line_rdata[8*c +: 8]),
            .weight (w_rdata),
            .res    (lane_res[c])
        );
    end

    assign win_cnt  = (win_rdata[16:11] > 6'(arr_pkg::TAPS_MAX)) ?
                      6'(arr_pkg::TAPS_MAX) : win_rdata[16:11];
    assign src      = 12'(first_reg) + 12'(k_reg);
    assign out_free = !out_vld_reg || m_tready;

    always_comb
    begin
        state_next     = state_reg;
        pr_next        = pr_reg;
        nout_next      = nout_reg;
        n_next         = n_reg;
        row_end_next   = row_end_reg;
        k_next         = k_reg;
        cnt_next       = cnt_reg;
        first_next     = first_reg;
        dvld_next      = 1'b0;
        din_next       = din_reg;
        held_vld_next  = held_vld_reg;
        held_pos_next  = held_pos_reg;
        held_res_next  = held_res_reg;
        held_fin_next  = held_fin_reg;
        s_tready       = 1'b0;
        w_we           = 1'b0;
        win_we         = 1'b0;
        line_we        = 1'b0;
        w_re           = 1'b0;
        win_re         = 1'b0;
        line_re        = 1'b0;
        lane_ctl.clear = 1'b0;
        lane_ctl.acc   = dvld_reg && din_reg;
        push           = 1'b0;
        push_last      = 1'b0;

        case (state_reg)
            arr_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    case (s_tuser)
                        arr_pkg::REQ_WEIGHT: w_we = 1'b1;
                        arr_pkg::REQ_WINDOW: win_we = 1'b1;
                        arr_pkg::REQ_PIXEL:
                        begin
                            line_we      = 1'b1;
                            pr_next      = pr_reg + 12'd1;
                            row_end_next = (pr_reg + 12'd1) >= in_w;
                            n_next       = 7'd0;
                            state_next   = arr_pkg::ST_WIN;
                        end
                        default: ;
                    endcase
                end
            end
            arr_pkg::ST_WIN:
            begin
                if (nout_reg >= out_w || n_reg == 7'(arr_pkg::RESULT_LIMIT))
                begin
                    state_next = arr_pkg::ST_FINISH;
                end
                else
                begin
                    win_re     = 1'b1;
                    state_next = arr_pkg::ST_CHECK;
                end
            end
            arr_pkg::ST_CHECK:
            begin
                if (!row_end_reg && (12'(win_rdata[10:0]) + 12'(win_cnt)) > pr_reg)
                begin
                    state_next = arr_pkg::ST_FINISH;
                end
                else if (!held_vld_reg || out_free)
                begin
                    // Another result follows, so the held one is not the last.
                    push           = held_vld_reg;
                    held_vld_next  = 1'b0;
                    k_next         = 6'd0;
                    cnt_next       = win_cnt;
                    first_next     = win_rdata[10:0];
                    lane_ctl.clear = 1'b1;
                    state_next     = arr_pkg::ST_TAP;
                end
            end
            arr_pkg::ST_TAP:
            begin
                if (k_reg < cnt_reg)
                begin
                    w_re      = 1'b1;
                    line_re   = 1'b1;
                    dvld_next = 1'b1;
                    din_next  = src < in_w;
                    k_next    = k_reg + 6'd1;
                end
                else if (!dvld_reg)
                begin
                    state_next = arr_pkg::ST_STORE;
                end
            end
            arr_pkg::ST_STORE:
            begin
                held_vld_next = 1'b1;
                held_pos_next = nout_reg[9:0];
                held_fin_next = (nout_reg + 11'd1) == out_w;
                for (int c = 0; c < arr_pkg::LANES; c++)
                begin
                    held_res_next[8*c +: 8] = (3'(c) < chans) ? lane_res[c] : 8'd0;
                end
                nout_next  = nout_reg + 11'd1;
                n_next     = n_reg + 7'd1;
                state_next = arr_pkg::ST_WIN;
            end
            arr_pkg::ST_FINISH:
            begin
                if (!held_vld_reg || out_free)
                begin
                    push          = held_vld_reg;
                    push_last     = 1'b1;
                    held_vld_next = 1'b0;
                    if (row_end_reg)
                    begin
                        pr_next   = 12'd0;
                        nout_next = 11'd0;
                    end
                    state_next = arr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = arr_pkg::ST_IDLE;
            end
        endcase
    end

    // Output register.
    always_comb
    begin
        out_vld_next  = out_vld_reg && !m_tready;
        out_data_next = out_data_reg;
        out_last_next = out_last_reg;
        out_user_next = out_user_reg;
        if (push)
        begin
            out_vld_next  = 1'b1;
            out_data_next = {6'd0, held_res_reg, held_pos_reg};
            out_last_next = push_last;
            out_user_next = held_fin_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= arr_pkg::ST_IDLE;
            pr_reg       <= 12'd0;
            nout_reg     <= 11'd0;
            n_reg        <= 7'd0;
            row_end_reg  <= 1'b0;
            k_reg        <= 6'd0;
            dvld_reg     <= 1'b0;
            held_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pr_reg       <= pr_next;
            nout_reg     <= nout_next;
            n_reg        <= n_next;
            row_end_reg  <= row_end_next;
            k_reg        <= k_next;
            dvld_reg     <= dvld_next;
            held_vld_reg <= held_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg      <= cnt_next;
        first_reg    <= first_next;
        din_reg      <= din_next;
        held_pos_reg <= held_pos_next;
        held_res_reg <= held_res_next;
        held_fin_reg <= held_fin_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        out_user_reg <= out_user_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_user_reg;

endmodule

>>> rtl/core/arr_checker.sv
// Port-level checks of the row resampler, bound to the top level.
// Depends on antialias_row_resampler_unit_macros.svh and arr_pkg.
`include "antialias_row_resampler_unit_macros.svh"

module arr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tlast,
    input logic        m_tuser
);

    // A stalled result beat keeps its contents.
    `ARR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // The final output of a row always closes the run of its pixel.
    `ARR_ASSERT_NOW(a_row_end_last, m_tvalid && m_tuser, m_tlast)

    // Once a pixel is taken the block is busy in the next cycle.
    `ARR_ASSERT_NEXT(a_pixel_busy,
        s_tvalid && s_tready && s_tuser == arr_pkg::REQ_PIXEL, !s_tready)

endmodule

bind antialias_row_resampler_unit arr_checker u_arr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
